// File: hdl/rcmix_pkg.sv
// Shared types, register indexes and reset values for the RC arming and setpoint mixer.
package rcmix_pkg;

	localparam int FRAC_BITS_DEF       = 8;
	localparam int CHANNEL_DIVISOR_DEF = 30;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 15;

	localparam logic [14:0] ARM_THRESHOLD_RST  = 15'd750;
	localparam logic [14:0] ATTITUDE_LIMIT_RST = 15'd1500;
	localparam logic [14:0] HOLD_LIMIT_RST     = 15'd3750;
	localparam logic [14:0] YAW_DEADBAND_RST   = 15'd150;
	localparam logic [7:0]  ARM_TICKS_RST      = 8'd5;
	localparam logic [7:0]  ARMED_RELOAD_RST   = 8'd6;
	localparam logic [7:0]  DISARM_FLOOR_RST   = 8'd2;

	localparam logic [7:0] COUNT_MAX = 8'd255;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_ARM_THRESHOLD  = 3'd0,
		CFG_ATTITUDE_LIMIT = 3'd1,
		CFG_HOLD_LIMIT     = 3'd2,
		CFG_YAW_DEADBAND   = 3'd3,
		CFG_ARM_TICKS      = 3'd4,
		CFG_ARMED_RELOAD   = 3'd5,
		CFG_DISARM_FLOOR   = 3'd6
	} cfg_index_t;

	typedef enum logic [1:0] {
		PH_DISARMED = 2'd0,
		PH_ARMING   = 2'd1,
		PH_ARMED    = 2'd2
	} phase_t;

	typedef enum logic [1:0] {
		AXIS_UNSET    = 2'd0,
		AXIS_ATTITUDE = 2'd1,
		AXIS_RATE     = 2'd2,
		AXIS_HOLD     = 2'd3
	} axis_mode_t;

	typedef struct packed {
		logic signed [15:0] stick_pitch;
		logic signed [15:0] stick_roll;
		logic signed [15:0] stick_throttle;
		logic signed [15:0] stick_yaw;
		logic signed [15:0] stick_mode;
		logic signed [23:0] throttle_offset;
		logic signed [23:0] pitch_offset;
		logic signed [23:0] roll_offset;
		logic signed [23:0] yaw_measured;
		logic               imu_external;
	} stick_word_t;

	typedef struct packed {
		logic signed [23:0] mode_value;
		logic signed [23:0] throttle_set;
		logic signed [23:0] pitch_set;
		logic signed [23:0] roll_set;
		logic signed [23:0] yaw_set;
		logic [1:0]         roll_axis_mode;
		logic [1:0]         pitch_axis_mode;
		logic [1:0]         yaw_axis_mode;
		logic [1:0]         fourth_axis_mode;
		logic [1:0]         arm_state;
		logic               lamp_on;
	} set_word_t;

endpackage

// File: hdl/rc_arming_and_setpoint_mixer.sv
// RC arming state machine and stick-to-setpoint mixer, three register stages.
//
//   channel   direction  handshake                 word
//   stick     in         stick_valid / stick_stall  rcmix_pkg::stick_word_t
//   set       out        set_valid / set_stall      rcmix_pkg::set_word_t
//   cfg       in         cfg_wen                    cfg_index, cfg_data
//
// One word per cycle sustained while set_stall is low; an accepted word passes through stages 1, 2 and 3 to set.
// Stage 1 holds the accepted word, stage 2 the constant-reciprocal products and the new
// arm state, stage 3 the offset sums after saturation.
// Reset clears all valid flags, the arm state, the yaw latch and the configuration registers to defaults.
// A stage advances when the stage after it is empty or advancing; stall on set holds a full stage 3.
module rc_arming_and_setpoint_mixer #(
	parameter int FRAC_BITS       = rcmix_pkg::FRAC_BITS_DEF,
	parameter int CHANNEL_DIVISOR = rcmix_pkg::CHANNEL_DIVISOR_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                stick_valid,
	output logic                                stick_stall,
	input  rcmix_pkg::stick_word_t              stick_word,
	output logic                                set_valid,
	input  logic                                set_stall,
	output rcmix_pkg::set_word_t                set_word,
	input  logic                                cfg_wen,
	input  logic [rcmix_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [rcmix_pkg::CFG_DATA_W-1:0]    cfg_data
);

	localparam int QW    = 16 + FRAC_BITS;
	localparam int SHIFT = 24;
	localparam int RW    = SHIFT + FRAC_BITS + 1;
	localparam int PW    = 16 + RW;
	localparam int SUMW  = ((QW + 1 > 24) ? (QW + 1) : 24) + 1;
	localparam logic [RW-1:0] RECIP =
		RW'(((64'd1 << (SHIFT + FRAC_BITS)) + 64'(CHANNEL_DIVISOR) - 64'd1)
			/ 64'(CHANNEL_DIVISOR));
	localparam logic [SUMW-1:0] SAT_MAX = {{(SUMW-23){1'b0}}, {23{1'b1}}};
	localparam logic [SUMW-1:0] SAT_MIN = {{(SUMW-23){1'b1}}, {23{1'b0}}};

	function automatic logic [QW-1:0] scale_mag(input logic [15:0] mag);
		logic [PW-1:0] prod;
		prod = PW'(mag) * PW'(RECIP);
		return prod[SHIFT +: QW];
	endfunction

	function automatic logic [15:0] abs16(input logic [15:0] v);
		return v[15] ? 16'(-v) : v;
	endfunction

	function automatic logic [23:0] add_sat(input logic [QW-1:0] q, input logic neg,
		input logic [23:0] off);
		logic [SUMW-1:0] qx;
		logic [SUMW-1:0] ox;
		logic [SUMW-1:0] s;
		qx = {{(SUMW-QW){1'b0}}, q};
		ox = {{(SUMW-24){off[23]}}, off};
		s  = (qx ^ {SUMW{neg}}) + ox + SUMW'(neg);
		if ($signed(s) > $signed(SAT_MAX)) begin
			return SAT_MAX[23:0];
		end else if ($signed(s) < $signed(SAT_MIN)) begin
			return SAT_MIN[23:0];
		end else begin
			return s[23:0];
		end
	endfunction

	// configuration registers
	logic [14:0] arm_threshold_q, attitude_limit_q, hold_limit_q, yaw_deadband_q;
	logic [7:0]  arm_ticks_q, armed_reload_q, disarm_floor_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			arm_threshold_q  <= rcmix_pkg::ARM_THRESHOLD_RST;
			attitude_limit_q <= rcmix_pkg::ATTITUDE_LIMIT_RST;
			hold_limit_q     <= rcmix_pkg::HOLD_LIMIT_RST;
			yaw_deadband_q   <= rcmix_pkg::YAW_DEADBAND_RST;
			arm_ticks_q      <= rcmix_pkg::ARM_TICKS_RST;
			armed_reload_q   <= rcmix_pkg::ARMED_RELOAD_RST;
			disarm_floor_q   <= rcmix_pkg::DISARM_FLOOR_RST;
		end else if (cfg_wen) begin
			unique case (rcmix_pkg::cfg_index_t'(cfg_index))
				rcmix_pkg::CFG_ARM_THRESHOLD:  arm_threshold_q  <= cfg_data;
				rcmix_pkg::CFG_ATTITUDE_LIMIT: attitude_limit_q <= cfg_data;
				rcmix_pkg::CFG_HOLD_LIMIT:     hold_limit_q     <= cfg_data;
				rcmix_pkg::CFG_YAW_DEADBAND:   yaw_deadband_q   <= cfg_data;
				rcmix_pkg::CFG_ARM_TICKS:      arm_ticks_q      <= cfg_data[7:0];
				rcmix_pkg::CFG_ARMED_RELOAD:   armed_reload_q   <= cfg_data[7:0];
				rcmix_pkg::CFG_DISARM_FLOOR:   disarm_floor_q   <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

	// stage flow control
	logic valid_s1, valid_s2, set_valid_q;
	logic adv1, adv2, adv3;

	assign adv3        = !set_valid_q || !set_stall;
	assign adv2        = !valid_s2 || adv3;
	assign adv1        = !valid_s1 || adv2;
	assign stick_stall = !adv1;
	assign set_valid   = set_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			set_valid_q <= 1'b0;
		end else begin
			if (adv1) begin
				valid_s1 <= stick_valid;
			end
			if (adv2) begin
				valid_s2 <= valid_s1;
			end
			if (adv3) begin
				set_valid_q <= valid_s2;
			end
		end
	end

	// stage 1: accepted word
	rcmix_pkg::stick_word_t word_s1;

	always_ff @(posedge clk) begin
		if (adv1 && stick_valid) begin
			word_s1 <= stick_word;
		end
	end

	// stage 1 decode: magnitudes, compares and arm machine
	logic [15:0] mag_pitch, mag_roll, mag_thr, mag_yaw, mag_mode;
	logic signed [16:0] mode_x;
	logic yaw_active, request;
	logic below_attitude, below_hold;

	assign mag_pitch = abs16(word_s1.stick_pitch);
	assign mag_roll  = abs16(word_s1.stick_roll);
	assign mag_thr   = abs16(word_s1.stick_throttle);
	assign mag_yaw   = abs16(word_s1.stick_yaw);
	assign mag_mode  = abs16(word_s1.stick_mode);

	assign mode_x         = {word_s1.stick_mode[15], word_s1.stick_mode};
	assign yaw_active     = mag_yaw > {1'b0, yaw_deadband_q};
	assign request        = !word_s1.imu_external && (mode_x > $signed({2'b00, arm_threshold_q}));
	assign below_attitude = mode_x < $signed({2'b00, attitude_limit_q});
	assign below_hold     = mode_x < $signed({2'b00, hold_limit_q});

	rcmix_pkg::phase_t     phase_q, phase_d;
	logic [7:0]            count_q, count_d;
	rcmix_pkg::axis_mode_t modes_q [4];
	rcmix_pkg::axis_mode_t modes_d [4];
	logic [23:0]           held_yaw_q;
	logic                  yaw_was_active_q;
	logic                  tick;

	assign tick = adv2 && valid_s1;

	always_comb begin
		logic [7:0] cnt_up;
		logic [7:0] cnt_dn;
		cnt_up  = (count_q == rcmix_pkg::COUNT_MAX) ? count_q : count_q + 8'd1;
		cnt_dn  = (count_q == 8'd0) ? count_q : count_q - 8'd1;
		phase_d = phase_q;
		count_d = count_q;
		modes_d = modes_q;
		if (request) begin
			unique case (phase_q)
				rcmix_pkg::PH_ARMING: begin
					count_d = cnt_up;
					if (cnt_up > arm_ticks_q) begin
						phase_d = rcmix_pkg::PH_ARMED;
					end
				end
				rcmix_pkg::PH_ARMED: begin
					modes_d[0] = rcmix_pkg::AXIS_ATTITUDE;
					modes_d[1] = rcmix_pkg::AXIS_ATTITUDE;
					if (below_attitude) begin
						modes_d[2] = rcmix_pkg::AXIS_RATE;
						modes_d[3] = rcmix_pkg::AXIS_HOLD;
					end else if (below_hold) begin
						modes_d[2] = yaw_active ? rcmix_pkg::AXIS_RATE
							: rcmix_pkg::AXIS_ATTITUDE;
						modes_d[3] = rcmix_pkg::AXIS_HOLD;
					end else begin
						modes_d[2] = rcmix_pkg::AXIS_RATE;
						modes_d[3] = rcmix_pkg::AXIS_RATE;
					end
					count_d = armed_reload_q;
				end
				default: begin
					phase_d = rcmix_pkg::PH_ARMING;
					count_d = 8'd0;
				end
			endcase
		end else begin
			if (phase_q == rcmix_pkg::PH_ARMED) begin
				count_d = cnt_dn;
				if (cnt_dn < disarm_floor_q) begin
					phase_d = rcmix_pkg::PH_DISARMED;
				end
			end else begin
				count_d = 8'd0;
				phase_d = rcmix_pkg::PH_DISARMED;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q          <= rcmix_pkg::PH_DISARMED;
			count_q          <= 8'd0;
			modes_q          <= '{default: rcmix_pkg::AXIS_UNSET};
			held_yaw_q       <= 24'd0;
			yaw_was_active_q <= 1'b0;
		end else if (tick) begin
			phase_q          <= phase_d;
			count_q          <= count_d;
			modes_q          <= modes_d;
			yaw_was_active_q <= yaw_active;
			if (!yaw_active && yaw_was_active_q) begin
				held_yaw_q <= word_s1.yaw_measured;
			end
		end
	end

	// stage 2: products and arm outcome
	logic [QW-1:0] q_pitch_s2, q_roll_s2, q_thr_s2, q_yaw_s2, q_mode_s2;
	logic          n_pitch_s2, n_roll_s2, n_thr_s2, n_yaw_s2, n_mode_s2;
	logic [23:0]   off_thr_s2, off_pitch_s2, off_roll_s2, held_s2;
	logic          imu_s2, yaw_active_s2, request_s2;
	rcmix_pkg::axis_mode_t modes_s2 [4];
	rcmix_pkg::phase_t     phase_s2;

	always_ff @(posedge clk) begin
		if (tick) begin
			q_pitch_s2    <= scale_mag(mag_pitch);
			q_roll_s2     <= scale_mag(mag_roll);
			q_thr_s2      <= scale_mag(mag_thr);
			q_yaw_s2      <= scale_mag(mag_yaw);
			q_mode_s2     <= scale_mag(mag_mode);
			n_pitch_s2    <= word_s1.stick_pitch[15];
			n_roll_s2     <= word_s1.stick_roll[15];
			n_thr_s2      <= word_s1.stick_throttle[15];
			n_yaw_s2      <= word_s1.stick_yaw[15];
			n_mode_s2     <= word_s1.stick_mode[15];
			off_thr_s2    <= word_s1.throttle_offset;
			off_pitch_s2  <= word_s1.pitch_offset;
			off_roll_s2   <= word_s1.roll_offset;
			held_s2       <= held_yaw_q;
			imu_s2        <= word_s1.imu_external;
			yaw_active_s2 <= yaw_active;
			request_s2    <= request;
			modes_s2      <= modes_d;
			phase_s2      <= phase_d;
		end
	end

	// stage 3: offset sums and saturation
	rcmix_pkg::set_word_t set_word_q;

	always_ff @(posedge clk) begin
		if (adv3 && valid_s2) begin
			set_word_q.mode_value   <= imu_s2 ? 24'sd0
				: add_sat(q_mode_s2, n_mode_s2, 24'd0);
			set_word_q.throttle_set <= add_sat(q_thr_s2, n_thr_s2, off_thr_s2);
			set_word_q.pitch_set    <= add_sat(q_pitch_s2, n_pitch_s2, off_pitch_s2);
			set_word_q.roll_set     <= add_sat(q_roll_s2, n_roll_s2, off_roll_s2);
			set_word_q.yaw_set      <= yaw_active_s2 ? add_sat(q_yaw_s2, n_yaw_s2, 24'd0)
				: held_s2;
			set_word_q.roll_axis_mode   <= modes_s2[0];
			set_word_q.pitch_axis_mode  <= modes_s2[1];
			set_word_q.yaw_axis_mode    <= modes_s2[2];
			set_word_q.fourth_axis_mode <= modes_s2[3];
			set_word_q.arm_state        <= phase_s2;
			set_word_q.lamp_on          <= request_s2;
		end
	end

	assign set_word = set_word_q;

endmodule

// File: test/tb_top.sv
// Testbench for the RC mixer: random and directed stick words checked against a tick predictor.
`timescale 1ns / 100ps

module tb_top;
	import rcmix_pkg::*;

	typedef struct {
		stick_word_t word;
		bit          calm;
	} pending_tick_t;

	logic                   clk         = 1'b0;
	logic                   arst_n      = 1'b0;
	logic                   stick_valid = 1'b0;
	logic                   stick_stall;
	stick_word_t            stick_word  = '0;
	logic                   set_valid;
	logic                   set_stall   = 1'b0;
	set_word_t              set_word;
	logic                   cfg_wen     = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index   = '0;
	logic [CFG_DATA_W-1:0]  cfg_data    = '0;

	pending_tick_t stick_q[$];
	set_word_t     sets_due[$];
	int            ticks_made = 0;
	int unsigned   idle_left  = 0;
	int unsigned   stall_left = 0;
	int unsigned   calm_left  = 0;
	int            mismatches = 0;
	int            strays     = 0;

	int arm_thr    = ARM_THRESHOLD_RST;
	int att_lim    = ATTITUDE_LIMIT_RST;
	int hold_lim   = HOLD_LIMIT_RST;
	int yaw_band   = YAW_DEADBAND_RST;
	int tick_goal  = ARM_TICKS_RST;
	int reload_val = ARMED_RELOAD_RST;
	int floor_val  = DISARM_FLOOR_RST;

	phase_t             phase_now   = PH_DISARMED;
	logic [7:0]         arm_count   = '0;
	logic signed [23:0] yaw_hold    = '0;
	bit                 yaw_was_out = 1'b0;
	axis_mode_t         axis_set[4] = '{AXIS_UNSET, AXIS_UNSET, AXIS_UNSET, AXIS_UNSET};

	rc_arming_and_setpoint_mixer dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.stick_valid (stick_valid),
		.stick_stall (stick_stall),
		.stick_word  (stick_word),
		.set_valid   (set_valid),
		.set_stall   (set_stall),
		.set_word    (set_word),
		.cfg_wen     (cfg_wen),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic longint scaled(logic signed [15:0] ch);
		return (longint'(ch) * (longint'(1) << FRAC_BITS_DEF)) / longint'(CHANNEL_DIVISOR_DEF);
	endfunction

	function automatic logic signed [23:0] clip24(longint v);
		if (v > longint'(8388607))
			return 24'sh7fffff;
		if (v < longint'(-8388608))
			return 24'sh800000;
		return v[23:0];
	endfunction

	function automatic set_word_t mix_tick(stick_word_t w);
		set_word_t r;
		longint    md;
		longint    yv;
		bit        yaw_out;
		bit        request;
		md = w.stick_mode;
		yv = w.stick_yaw;
		if (yv < 0)
			yv = -yv;
		r.mode_value   = w.imu_external ? 24'sd0 : clip24(scaled(w.stick_mode));
		r.throttle_set = clip24(scaled(w.stick_throttle) + longint'(w.throttle_offset));
		r.pitch_set    = clip24(scaled(w.stick_pitch) + longint'(w.pitch_offset));
		r.roll_set     = clip24(scaled(w.stick_roll) + longint'(w.roll_offset));
		yaw_out = (yv > yaw_band);
		r.yaw_set = yaw_out ? clip24(scaled(w.stick_yaw)) : yaw_hold;
		if (!yaw_out && yaw_was_out)
			yaw_hold = w.yaw_measured;
		yaw_was_out = yaw_out;
		request = !w.imu_external && (md > arm_thr);
		if (request) begin
			case (phase_now)
				PH_ARMING: begin
					if (arm_count != COUNT_MAX)
						arm_count++;
					if (arm_count > tick_goal)
						phase_now = PH_ARMED;
				end
				PH_ARMED: begin
					if (md < att_lim)
						axis_set = '{AXIS_ATTITUDE, AXIS_ATTITUDE, AXIS_RATE, AXIS_HOLD};
					else if (md < hold_lim)
						axis_set = '{AXIS_ATTITUDE, AXIS_ATTITUDE,
							yaw_out ? AXIS_RATE : AXIS_ATTITUDE, AXIS_HOLD};
					else
						axis_set = '{AXIS_ATTITUDE, AXIS_ATTITUDE, AXIS_RATE, AXIS_RATE};
					arm_count = reload_val[7:0];
				end
				default: begin
					phase_now = PH_ARMING;
					arm_count = '0;
				end
			endcase
		end else if (phase_now == PH_ARMED) begin
			if (arm_count != 0)
				arm_count--;
			if (arm_count < floor_val)
				phase_now = PH_DISARMED;
		end else begin
			arm_count = '0;
			phase_now = PH_DISARMED;
		end
		r.roll_axis_mode   = axis_set[0];
		r.pitch_axis_mode  = axis_set[1];
		r.yaw_axis_mode    = axis_set[2];
		r.fourth_axis_mode = axis_set[3];
		r.arm_state        = phase_now;
		r.lamp_on          = request;
		return r;
	endfunction

	function automatic int unsigned gap_len();
		int unsigned r;
		r = $urandom_range(0, 19);
		if (r < 12)
			return 0;
		if (r < 18)
			return $urandom_range(1, 3);
		return $urandom_range(4, 30);
	endfunction

	function automatic logic [15:0] rand16();
		case ($urandom_range(0, 9))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'(int'($urandom_range(0, 64)) - 32);
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [23:0] rand24();
		case ($urandom_range(0, 9))
			0: return 24'h800000;
			1: return 24'h7fffff;
			2: return 24'(int'($urandom_range(0, 4096)) - 2048);
			default: return 24'($urandom);
		endcase
	endfunction

	function automatic logic [15:0] pick_high();
		int v;
		case ($urandom_range(0, 5))
			0: v = att_lim + int'($urandom_range(0, 2)) - 1;
			1: v = hold_lim + int'($urandom_range(0, 2)) - 1;
			2: v = arm_thr + 1;
			3: v = 32767;
			default: v = $urandom_range(arm_thr, 32767);
		endcase
		if (v <= arm_thr)
			v = (arm_thr == 32767) ? 32767 : int'($urandom_range(arm_thr + 1, 32767));
		if (v > 32767)
			v = 32767;
		return v[15:0];
	endfunction

	function automatic logic [15:0] pick_low();
		int v;
		if ($urandom_range(0, 7) == 0)
			v = arm_thr;
		else
			v = int'($urandom_range(0, arm_thr + 32768)) - 32768;
		return v[15:0];
	endfunction

	function automatic logic [15:0] pick_yaw();
		int v;
		case ($urandom_range(0, 7))
			0: v = yaw_band;
			1: v = -yaw_band;
			2: v = yaw_band + 1;
			3: v = -yaw_band - 1;
			4: v = -32768;
			5, 6: begin
				v = $urandom_range(0, yaw_band);
				if ($urandom_range(0, 1) == 1)
					v = -v;
			end
			default: v = int'($urandom_range(0, 65535)) - 32768;
		endcase
		if (v > 32767)
			v = 32767;
		return v[15:0];
	endfunction

	function automatic stick_word_t make_word(logic [15:0] mode, logic [15:0] yaw, logic imu);
		stick_word_t w;
		w.stick_pitch     = rand16();
		w.stick_roll      = rand16();
		w.stick_throttle  = rand16();
		w.stick_yaw       = yaw;
		w.stick_mode      = mode;
		w.throttle_offset = rand24();
		w.pitch_offset    = rand24();
		w.roll_offset     = rand24();
		w.yaw_measured    = rand24();
		w.imu_external    = imu;
		return w;
	endfunction

	task automatic add_tick(stick_word_t w, bit calm);
		pending_tick_t t;
		t.word = w;
		t.calm = calm;
		stick_q.push_back(t);
		ticks_made++;
	endtask

	task automatic add_random(int count);
		int          target;
		int          len;
		int          n;
		bit          calm;
		logic [15:0] mode;
		target = ticks_made + count;
		while (ticks_made < target) begin
			calm = ($urandom_range(0, 4) == 0);
			case ($urandom_range(0, 9))
				6, 7: begin
					len = $urandom_range(1, 10);
					for (n = 0; n < len; n++)
						add_tick(make_word(16'($urandom), 16'($urandom), 1'($urandom)), calm);
				end
				8, 9: begin
					mode = pick_high();
					len = $urandom_range(1, (tick_goal < 30 ? tick_goal : 30) + 10);
					for (n = 0; n < len; n++)
						add_tick(make_word(mode, pick_yaw(), 1'b0), calm);
					mode = pick_low();
					len = $urandom_range(1, 12);
					for (n = 0; n < len; n++)
						add_tick(make_word(mode, pick_yaw(), 1'b0), calm);
				end
				default: begin
					len = $urandom_range(1, (tick_goal < 30 ? tick_goal : 30) + 10);
					for (n = 0; n < len; n++)
						add_tick(make_word(pick_high(), pick_yaw(),
							$urandom_range(0, 24) == 0), calm);
					len = $urandom_range(1, 12);
					for (n = 0; n < len; n++)
						add_tick(make_word(pick_low(), pick_yaw(),
							$urandom_range(0, 5) == 0), calm);
				end
			endcase
		end
	endtask

	task automatic add_held_high(int count);
		int n;
		for (n = 0; n < count; n++)
			add_tick(make_word(pick_high(), pick_yaw(), 1'b0), 1'b0);
	endtask

	task automatic wait_idle();
		do
			@(negedge clk);
		while (stick_q.size() != 0 || stick_valid || sets_due.size() != 0);
		repeat (4) @(negedge clk);
	endtask

	task automatic cfg_write(cfg_index_t idx, int value);
		@(posedge clk);
		cfg_wen   <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value[CFG_DATA_W-1:0];
		case (idx)
			CFG_ARM_THRESHOLD:  arm_thr    = value & 32'h7fff;
			CFG_ATTITUDE_LIMIT: att_lim    = value & 32'h7fff;
			CFG_HOLD_LIMIT:     hold_lim   = value & 32'h7fff;
			CFG_YAW_DEADBAND:   yaw_band   = value & 32'h7fff;
			CFG_ARM_TICKS:      tick_goal  = value & 32'hff;
			CFG_ARMED_RELOAD:   reload_val = value & 32'hff;
			CFG_DISARM_FLOOR:   floor_val  = value & 32'hff;
			default: ;
		endcase
	endtask

	task automatic set_config(int thr, int att, int hold, int band, int goal, int reload,
		int floor_v);
		cfg_write(CFG_ARM_THRESHOLD, thr);
		cfg_write(CFG_ATTITUDE_LIMIT, att);
		cfg_write(CFG_HOLD_LIMIT, hold);
		cfg_write(CFG_YAW_DEADBAND, band);
		cfg_write(CFG_ARM_TICKS, goal);
		cfg_write(CFG_ARMED_RELOAD, reload);
		cfg_write(CFG_DISARM_FLOOR, floor_v);
		@(posedge clk);
		cfg_wen <= 1'b0;
		@(negedge clk);
	endtask

	task automatic check_field(string name, logic [23:0] want, logic [23:0] got);
		if (want !== got) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%s: expected %h, got %h", name, want, got);
		end
	endtask

	always @(posedge clk) begin : drive
		pending_tick_t head;
		if (arst_n) begin
			if (stick_valid && !stick_stall)
				sets_due.push_back(mix_tick(stick_word));
			if (!stick_valid || !stick_stall) begin
				if (idle_left != 0) begin
					idle_left   <= idle_left - 1;
					stick_valid <= 1'b0;
				end else if (stick_q.size() != 0) begin
					head = stick_q.pop_front();
					stick_word  <= head.word;
					stick_valid <= 1'b1;
					idle_left   <= head.calm ? 0 : gap_len();
				end else begin
					stick_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin : watch
		set_word_t   want;
		int unsigned pick;
		if (arst_n) begin
			if (set_valid && !set_stall) begin
				if (sets_due.size() == 0) begin
					strays++;
					if (strays <= 10)
						$display("unexpected set word %h", set_word);
				end else begin
					want = sets_due.pop_front();
					check_field("mode_value", want.mode_value, set_word.mode_value);
					check_field("throttle_set", want.throttle_set, set_word.throttle_set);
					check_field("pitch_set", want.pitch_set, set_word.pitch_set);
					check_field("roll_set", want.roll_set, set_word.roll_set);
					check_field("yaw_set", want.yaw_set, set_word.yaw_set);
					check_field("roll_axis_mode", want.roll_axis_mode, set_word.roll_axis_mode);
					check_field("pitch_axis_mode", want.pitch_axis_mode,
						set_word.pitch_axis_mode);
					check_field("yaw_axis_mode", want.yaw_axis_mode, set_word.yaw_axis_mode);
					check_field("fourth_axis_mode", want.fourth_axis_mode,
						set_word.fourth_axis_mode);
					check_field("arm_state", want.arm_state, set_word.arm_state);
					check_field("lamp_on", want.lamp_on, set_word.lamp_on);
				end
			end
			if (calm_left != 0) begin
				calm_left <= calm_left - 1;
				set_stall <= 1'b0;
			end else if (stall_left != 0) begin
				stall_left <= stall_left - 1;
				set_stall  <= 1'b1;
			end else begin
				pick = $urandom_range(0, 99);
				if (pick < 2) begin
					calm_left <= $urandom_range(40, 200);
					set_stall <= 1'b0;
				end else if (pick < 30) begin
					stall_left <= gap_len();
					set_stall  <= 1'b1;
				end else begin
					set_stall <= 1'b0;
				end
			end
		end
	end

	initial begin : main
		stick_word_t w;
		int          n;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		w = '{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh8000,
			24'sh7fffff, 24'sh7fffff, 24'sh7fffff, 24'sh7fffff, 1'b0};
		add_tick(w, 1'b0);
		w = '{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh0000,
			24'sh800000, 24'sh800000, 24'sh800000, 24'sh800000, 1'b0};
		add_tick(w, 1'b0);
		w = make_word(16'sd0, 16'sd150, 1'b0);
		w.yaw_measured = 24'sh7fffff;
		add_tick(w, 1'b0);
		add_tick(make_word(16'sd0, -16'sd151, 1'b0), 1'b0);
		w = make_word(16'sd0, -16'sd150, 1'b0);
		w.yaw_measured = 24'sh800000;
		add_tick(w, 1'b0);
		add_tick(make_word(16'sd0, 16'sd0, 1'b0), 1'b0);
		add_tick(make_word(16'sd751, 16'sd0, 1'b1), 1'b0);
		add_tick(make_word(16'sd750, 16'sd0, 1'b0), 1'b0);
		for (n = 0; n < 7; n++)
			add_tick(make_word(16'sd751, 16'sd0, 1'b0), 1'b0);
		add_tick(make_word(16'sd1000, 16'sd0, 1'b0), 1'b0);
		add_tick(make_word(16'sd1500, 16'sd151, 1'b0), 1'b0);
		add_tick(make_word(16'sd3749, 16'sd0, 1'b0), 1'b0);
		add_tick(make_word(16'sd3750, 16'sd0, 1'b0), 1'b0);
		add_tick(make_word(16'sd32767, 16'sd0, 1'b1), 1'b0);
		for (n = 0; n < 4; n++)
			add_tick(make_word(16'sd0, 16'sd0, 1'b0), 1'b0);
		add_random(250);
		wait_idle();

		set_config(0, 0, 0, 0, 1, 1, 0);
		add_random(150);
		wait_idle();

		set_config(32767, 32767, 32767, 32767, 255, 255, 255);
		add_random(120);
		wait_idle();

		set_config(100, 200, 300, 0, 255, 255, 0);
		add_held_high(270);
		add_random(80);
		wait_idle();

		set_config(100, 2000, 4000, 500, 254, 255, 255);
		add_held_high(260);
		add_random(80);
		wait_idle();

		repeat (3) begin
			set_config($urandom_range(0, 3000), $urandom_range(0, 6000),
				$urandom_range(0, 9000), $urandom_range(0, 2000),
				$urandom_range(1, 12), $urandom_range(1, 12), $urandom_range(0, 14));
			add_random(150);
			wait_idle();
		end

		repeat (8) @(posedge clk);
		if (mismatches == 0 && strays == 0 && sets_due.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		#3_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule

// File: sim.f
hdl/rcmix_pkg.sv
hdl/rc_arming_and_setpoint_mixer.sv
test/tb_top.sv
